FILE: rtl/dual_axis_stepper_move_sequencer_assert.svh
// assertion macros for the move sequencer
`ifndef DUAL_AXIS_STEPPER_MOVE_SEQUENCER_ASSERT_SVH
`define DUAL_AXIS_STEPPER_MOVE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define DASMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DASMS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DASMS_ASSERT(label, prop, msg)
`define DASMS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/dasms_pkg.sv
`default_nettype none

package dasms_pkg;

    localparam int POS_W = 4;
    localparam int DELTA_W = POS_W + 1;
    localparam int GROUP_W = 16;
    localparam logic [GROUP_W-1:0] GROUPS_PER_UNIT_RESET = 16'd512;

    typedef enum logic [0:0] {
        OP_MOVE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t              operation;
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
        logic             limit_top;
        logic             limit_bottom;
        logic             limit_left;
        logic             limit_right;
    } in_item_t;

    typedef struct packed {
        logic             coil_xa;
        logic             coil_xb;
        logic             coil_ya;
        logic             coil_yb;
        logic             busy_res;
        logic             done_res;
        logic [POS_W-1:0] position_x;
        logic [POS_W-1:0] position_y;
    } out_item_t;

    function automatic logic [DELTA_W-1:0] toward_zero(input logic [DELTA_W-1:0] d);
        logic [DELTA_W-1:0] r;
        if (d == '0)
            r = '0;
        else if (d[DELTA_W-1])
            r = d + DELTA_W'(1);
        else
            r = d - DELTA_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dual_axis_stepper_move_sequencer.sv
// Dual-axis stepper move sequencer.
// Input channel in_valid/in_ready/in_data carries move commands and phase
// ticks with the four limit-switch levels; output channel
// out_valid/out_ready/out_data returns exactly one result per input
// transfer: coil levels, busy and done flags and the committed position.
// Write the step-group length through cfg_we/cfg_data only while idle; the
// block does not enforce this. Latency: the result of an input transfer is
// valid in the cycle after that transfer. Throughput: one item per cycle,
// set by the single state-update step between the state registers and the
// result register. When the receiver stalls, the result register holds its
// item and in_ready stays high only if that item is taken in the same
// cycle, so nothing is lost or repeated. Reset clears coils, position, the
// move state and the output valid, and sets the group length to 512.
`default_nettype none

`include "dual_axis_stepper_move_sequencer_assert.svh"

module dual_axis_stepper_move_sequencer
    import dasms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    input  wire logic               cfg_we,
    input  wire logic [GROUP_W-1:0] cfg_data
);

    logic [GROUP_W-1:0] gpu_reg;
    logic               level_xa_reg, level_xa_next;
    logic               level_xb_reg, level_xb_next;
    logic               level_ya_reg, level_ya_next;
    logic               level_yb_reg, level_yb_next;
    logic [POS_W-1:0]   current_x_reg, current_x_next;
    logic [POS_W-1:0]   current_y_reg, current_y_next;
    logic [POS_W-1:0]   goal_x_reg, goal_x_next;
    logic [POS_W-1:0]   goal_y_reg, goal_y_next;
    logic [DELTA_W-1:0] delta_x_reg, delta_x_next;
    logic [DELTA_W-1:0] delta_y_reg, delta_y_next;
    logic [GROUP_W-1:0] group_count_reg, group_count_next;
    logic [1:0]         phase_reg, phase_next;
    logic               allow_x_reg, allow_x_next;
    logic               allow_y_reg, allow_y_next;
    logic               moving_reg, moving_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg, out_data_next;

    logic               in_fire;
    logic               done;
    logic               fwd_x, fwd_y;
    logic               lim_x, lim_y;
    logic               act_x, act_y;
    logic               hit_xa, hit_ya;
    logic [GROUP_W-1:0] group_inc;
    logic               unit_end;
    logic [DELTA_W-1:0] cmd_dx, cmd_dy;
    logic [DELTA_W-1:0] tz_x, tz_y;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cmd_dx = {1'b0, in_data.target_x} - {1'b0, current_x_reg};
    assign cmd_dy = {1'b0, in_data.target_y} - {1'b0, current_y_reg};

    assign fwd_x = !delta_x_reg[DELTA_W-1] && (delta_x_reg != '0);
    assign fwd_y = !delta_y_reg[DELTA_W-1] && (delta_y_reg != '0);
    assign lim_x = fwd_x ? in_data.limit_right : in_data.limit_left;
    assign lim_y = fwd_y ? in_data.limit_top : in_data.limit_bottom;

    // limits sampled on the first tick of a group
    assign act_x = (phase_reg == 2'd0) ? ((delta_x_reg != '0) && !lim_x) : allow_x_reg;
    assign act_y = (phase_reg == 2'd0) ? ((delta_y_reg != '0) && !lim_y) : allow_y_reg;
    assign hit_xa = phase_reg[0] ? !fwd_x : fwd_x;
    assign hit_ya = phase_reg[0] ? !fwd_y : fwd_y;

    assign group_inc = group_count_reg + GROUP_W'(1);
    assign unit_end  = (group_inc == '0) || (group_inc >= gpu_reg);
    assign tz_x      = toward_zero(delta_x_reg);
    assign tz_y      = toward_zero(delta_y_reg);

    always_comb
    begin
        level_xa_next    = level_xa_reg;
        level_xb_next    = level_xb_reg;
        level_ya_next    = level_ya_reg;
        level_yb_next    = level_yb_reg;
        current_x_next   = current_x_reg;
        current_y_next   = current_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        group_count_next = group_count_reg;
        phase_next       = phase_reg;
        allow_x_next     = allow_x_reg;
        allow_y_next     = allow_y_reg;
        moving_next      = moving_reg;
        done             = 1'b0;

        case (in_data.operation)
            OP_MOVE:
            begin
                if (!moving_reg)
                begin
                    goal_x_next      = in_data.target_x;
                    goal_y_next      = in_data.target_y;
                    delta_x_next     = cmd_dx;
                    delta_y_next     = cmd_dy;
                    group_count_next = '0;
                    phase_next       = 2'd0;
                    allow_x_next     = 1'b0;
                    allow_y_next     = 1'b0;
                    if ((cmd_dx == '0) && (cmd_dy == '0))
                    begin
                        current_x_next = in_data.target_x;
                        current_y_next = in_data.target_y;
                        done           = 1'b1;
                    end
                    else
                    begin
                        moving_next = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (moving_reg)
                begin
                    allow_x_next = act_x;
                    allow_y_next = act_y;
                    if (act_x)
                    begin
                        level_xa_next = level_xa_reg ^ hit_xa;
                        level_xb_next = level_xb_reg ^ !hit_xa;
                    end
                    if (act_y)
                    begin
                        level_ya_next = level_ya_reg ^ hit_ya;
                        level_yb_next = level_yb_reg ^ !hit_ya;
                    end
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        if (unit_end)
                        begin
                            group_count_next = '0;
                            delta_x_next     = tz_x;
                            delta_y_next     = tz_y;
                            if ((tz_x == '0) && (tz_y == '0))
                            begin
                                current_x_next = goal_x_reg;
                                current_y_next = goal_y_reg;
                                moving_next    = 1'b0;
                                done           = 1'b1;
                            end
                        end
                        else
                        begin
                            group_count_next = group_inc;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        out_data_next.coil_xa    = level_xa_next;
        out_data_next.coil_xb    = level_xb_next;
        out_data_next.coil_ya    = level_ya_next;
        out_data_next.coil_yb    = level_yb_next;
        out_data_next.busy_res   = moving_next;
        out_data_next.done_res   = done;
        out_data_next.position_x = current_x_next;
        out_data_next.position_y = current_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpu_reg <= GROUPS_PER_UNIT_RESET;
        end
        else if (cfg_we)
        begin
            gpu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_xa_reg    <= 1'b0;
            level_xb_reg    <= 1'b0;
            level_ya_reg    <= 1'b0;
            level_yb_reg    <= 1'b0;
            current_x_reg   <= '0;
            current_y_reg   <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            group_count_reg <= '0;
            phase_reg       <= 2'd0;
            allow_x_reg     <= 1'b0;
            allow_y_reg     <= 1'b0;
            moving_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            level_xa_reg    <= level_xa_next;
            level_xb_reg    <= level_xb_next;
            level_ya_reg    <= level_ya_next;
            level_yb_reg    <= level_yb_next;
            current_x_reg   <= current_x_next;
            current_y_reg   <= current_y_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            group_count_reg <= group_count_next;
            phase_reg       <= phase_next;
            allow_x_reg     <= allow_x_next;
            allow_y_reg     <= allow_y_next;
            moving_reg      <= moving_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // move state consistency
    `DASMS_ASSERT_NEVER(a_moving_zero_delta, moving_reg && (delta_x_reg == '0) && (delta_y_reg == '0), "moving with both deltas zero")
    `DASMS_ASSERT_NEVER(a_phase_idle, !moving_reg && (phase_reg != 2'd0), "phase advanced while idle")
    `DASMS_ASSERT_NEVER(a_done_busy, out_valid_reg && out_data_reg.done_res && out_data_reg.busy_res, "done and busy together")
    `DASMS_ASSERT(a_result_follows, in_fire |=> out_valid_reg, "no result after input transfer")

endmodule

`default_nettype wire

FILE: tb/tb_dual_axis_stepper_move_sequencer.sv
`timescale 1ns / 100ps

module tb_dual_axis_stepper_move_sequencer;
    import dasms_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 265;
    localparam int REPORT_LIMIT    = 40;

    typedef enum logic {
        ROW_XFER,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        in_item_t           item;
        int unsigned        reps;
        bit                 typed;
        out_item_t          want;
        logic [GROUP_W-1:0] groups;
        bit                 steady;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_we;
    logic [GROUP_W-1:0] cfg_data;

    // sequencer state as predicted
    logic                      lvl_xa, lvl_xb, lvl_ya, lvl_yb;
    logic [POS_W-1:0]          pos_x, pos_y, goal_x, goal_y;
    logic signed [DELTA_W-1:0] dist_x, dist_y;
    logic [GROUP_W-1:0]        group_cnt;
    logic [GROUP_W-1:0]        groups_per_unit;
    logic [1:0]                phase;
    logic                      drive_x, drive_y, move_active;

    out_item_t   status_due_q[$];
    plan_row_t   plan_q[$];
    out_item_t   head_want;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned burst_left;
    bit          steady_flow;
    bit          hold_off;

    dual_axis_stepper_move_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic logic signed [DELTA_W-1:0] shrink(input logic signed [DELTA_W-1:0] d);
        if (d > 0)
            return d - DELTA_W'(1);
        else if (d < 0)
            return d + DELTA_W'(1);
        return d;
    endfunction

    task automatic advance_sequencer(input in_item_t it, output out_item_t res);
        logic blocked_x, blocked_y, finished;
        finished = 1'b0;
        if (it.operation == OP_MOVE)
        begin
            if (!move_active)
            begin
                goal_x    = it.target_x;
                goal_y    = it.target_y;
                dist_x    = $signed({1'b0, it.target_x}) - $signed({1'b0, pos_x});
                dist_y    = $signed({1'b0, it.target_y}) - $signed({1'b0, pos_y});
                group_cnt = '0;
                phase     = 2'd0;
                drive_x   = 1'b0;
                drive_y   = 1'b0;
                if (dist_x == 0 && dist_y == 0)
                begin
                    pos_x    = goal_x;
                    pos_y    = goal_y;
                    finished = 1'b1;
                end
                else
                begin
                    move_active = 1'b1;
                end
            end
        end
        else if (move_active)
        begin
            if (phase == 2'd0)
            begin
                blocked_x = (dist_x > 0) ? it.limit_right : it.limit_left;
                blocked_y = (dist_y > 0) ? it.limit_top : it.limit_bottom;
                drive_x   = (dist_x != 0) && !blocked_x;
                drive_y   = (dist_y != 0) && !blocked_y;
            end
            // forward hits coil a on even phases, backward on odd ones
            if (drive_x)
            begin
                if ((phase[0] == 1'b0) == (dist_x > 0))
                    lvl_xa = ~lvl_xa;
                else
                    lvl_xb = ~lvl_xb;
            end
            if (drive_y)
            begin
                if ((phase[0] == 1'b0) == (dist_y > 0))
                    lvl_ya = ~lvl_ya;
                else
                    lvl_yb = ~lvl_yb;
            end
            if (phase == 2'd3)
            begin
                phase     = 2'd0;
                group_cnt = group_cnt + 1'b1;
                if (group_cnt == '0 || group_cnt >= groups_per_unit)
                begin
                    group_cnt = '0;
                    dist_x    = shrink(dist_x);
                    dist_y    = shrink(dist_y);
                    if (dist_x == 0 && dist_y == 0)
                    begin
                        pos_x       = goal_x;
                        pos_y       = goal_y;
                        move_active = 1'b0;
                        finished    = 1'b1;
                    end
                end
            end
            else
            begin
                phase = phase + 2'd1;
            end
        end
        res.coil_xa    = lvl_xa;
        res.coil_xb    = lvl_xb;
        res.coil_ya    = lvl_ya;
        res.coil_yb    = lvl_yb;
        res.busy_res   = move_active;
        res.done_res   = finished;
        res.position_x = pos_x;
        res.position_y = pos_y;
    endtask

    // limits are {top, bottom, left, right}
    function automatic in_item_t move_cmd(input logic [POS_W-1:0] tx, input logic [POS_W-1:0] ty,
                                          input logic [3:0] lim);
        in_item_t it;
        it.operation    = OP_MOVE;
        it.target_x     = tx;
        it.target_y     = ty;
        it.limit_top    = lim[3];
        it.limit_bottom = lim[2];
        it.limit_left   = lim[1];
        it.limit_right  = lim[0];
        return it;
    endfunction

    function automatic in_item_t tick_cmd(input logic [3:0] lim);
        in_item_t it;
        it           = move_cmd(POS_W'($urandom), POS_W'($urandom), lim);
        it.operation = OP_TICK;
        return it;
    endfunction

    function automatic logic [3:0] rand_limits();
        logic [3:0] lim;
        for (int i = 0; i < 4; i++)
            lim[i] = ($urandom_range(0, 5) == 0);
        return lim;
    endfunction

    function automatic out_item_t status(input logic [3:0] coils, input logic busy,
                                         input logic done, input logic [POS_W-1:0] px,
                                         input logic [POS_W-1:0] py);
        out_item_t s;
        {s.coil_xa, s.coil_xb, s.coil_ya, s.coil_yb} = coils;
        s.busy_res   = busy;
        s.done_res   = done;
        s.position_x = px;
        s.position_y = py;
        return s;
    endfunction

    function automatic void add_xfer(input in_item_t item, input int unsigned reps,
                                     input bit typed, input out_item_t want, input bit steady);
        plan_row_t row;
        row.kind   = ROW_XFER;
        row.item   = item;
        row.reps   = reps;
        row.typed  = typed;
        row.want   = want;
        row.groups = '0;
        row.steady = steady;
        plan_q.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [GROUP_W-1:0] value);
        plan_row_t row;
        row.kind   = ROW_CFG;
        row.item   = '0;
        row.reps   = 0;
        row.typed  = 1'b0;
        row.want   = '0;
        row.groups = value;
        row.steady = 1'b0;
        plan_q.push_back(row);
    endfunction

    task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        if (!steady_flow)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_sequencer(it, predicted);
        status_due_q.push_back(typed ? want : predicted);
    endtask

    task automatic write_groups(input logic [GROUP_W-1:0] value);
        in_valid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we          <= 1'b0;
        groups_per_unit = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due_q.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: result expected none got %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                head_want = status_due_q.pop_front();
                check_field("coil_xa", 8'(head_want.coil_xa), 8'(out_data.coil_xa));
                check_field("coil_xb", 8'(head_want.coil_xb), 8'(out_data.coil_xb));
                check_field("coil_ya", 8'(head_want.coil_ya), 8'(out_data.coil_ya));
                check_field("coil_yb", 8'(head_want.coil_yb), 8'(out_data.coil_yb));
                check_field("busy_res", 8'(head_want.busy_res), 8'(out_data.busy_res));
                check_field("done_res", 8'(head_want.done_res), 8'(out_data.done_res));
                check_field("position_x", 8'(head_want.position_x), 8'(out_data.position_x));
                check_field("position_y", 8'(head_want.position_y), 8'(out_data.position_y));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("tb_dual_axis_stepper_move_sequencer NOT OK");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (steady_flow)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    initial
    begin
        in_item_t           item;
        plan_row_t          row;
        int unsigned        counted;
        int unsigned        pick;
        logic [GROUP_W-1:0] groups;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        hold_off       = 1'b0;
        steady_flow    = 1'b0;
        burst_left     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;

        {lvl_xa, lvl_xb, lvl_ya, lvl_yb} = 4'b0000;
        pos_x           = '0;
        pos_y           = '0;
        goal_x          = '0;
        goal_y          = '0;
        dist_x          = '0;
        dist_y          = '0;
        group_cnt       = '0;
        phase           = 2'd0;
        drive_x         = 1'b0;
        drive_y         = 1'b0;
        move_active     = 1'b0;
        groups_per_unit = GROUPS_PER_UNIT_RESET;

        // idle tick, zero-length move, busy command, then part of a unit at the reset length
        add_xfer(tick_cmd(4'b1111), 1, 1'b1, status(4'b0000, 1'b0, 1'b0, 0, 0), 1'b0);
        add_xfer(move_cmd(0, 0, 4'b1111), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 0, 0), 1'b0);
        add_xfer(move_cmd(1, 0, 4'b1111), 1, 1'b1, status(4'b0000, 1'b1, 1'b0, 0, 0), 1'b0);
        add_xfer(move_cmd(15, 15, 4'b0000), 1, 1'b1, status(4'b0000, 1'b1, 1'b0, 0, 0), 1'b0);
        add_xfer(tick_cmd(4'b0000), 63, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b1, 1'b0, 0, 0), 1'b0);
        // shorter length ends the unit at the next group boundary
        add_cfg(16'd1);
        add_xfer(tick_cmd(4'b0000), 3, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 1, 0), 1'b0);
        // forward to the far corner with limits at group start and mid-group
        add_cfg(16'd1);
        add_xfer(move_cmd(15, 15, 4'b0000), 1, 1'b1, status(4'b0000, 1'b1, 1'b0, 1, 0), 1'b0);
        add_xfer(tick_cmd(4'b0001), 4, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b1000), 4, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b1111), 4, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0001), 3, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 43, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 15, 15), 1'b0);
        // backward to the origin
        add_xfer(move_cmd(0, 0, 4'b1111), 1, 1'b1, status(4'b0000, 1'b1, 1'b0, 15, 15), 1'b0);
        add_xfer(tick_cmd(4'b0010), 4, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0100), 4, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 51, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 0, 0), 1'b0);
        // zero length acts as one group per unit, back to back
        add_cfg(16'd0);
        add_xfer(move_cmd(2, 3, 4'b0000), 1, 1'b0, '0, 1'b1);
        add_xfer(tick_cmd(4'b0000), 11, 1'b0, '0, 1'b1);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 2, 3), 1'b1);
        // length lowered in the middle of a unit
        add_cfg(16'd6);
        add_xfer(move_cmd(4, 3, 4'b0000), 1, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 12, 1'b0, '0, 1'b0);
        add_cfg(16'd2);
        add_xfer(tick_cmd(4'b0000), 11, 1'b0, '0, 1'b0);
        add_xfer(tick_cmd(4'b0000), 1, 1'b1, status(4'b0000, 1'b0, 1'b1, 4, 3), 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.kind == ROW_CFG)
            begin
                write_groups(row.groups);
            end
            else
            begin
                steady_flow = row.steady;
                repeat (row.reps) push_item(row.item, row.typed, row.want);
            end
        end
        steady_flow = 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       groups = 16'd1;
                1:       groups = 16'd2;
                2:       groups = 16'd0;
                3:       groups = 16'd3;
                4:       groups = 16'd1;
                default: groups = GROUP_W'($urandom_range(1, 4));
            endcase
            write_groups(groups);
            if (p == 1)
                hold_off = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                if (move_active)
                begin
                    if ($urandom_range(0, 12) == 0)
                    begin
                        item = move_cmd(POS_W'($urandom), POS_W'($urandom), rand_limits());
                    end
                    else
                    begin
                        item = tick_cmd(rand_limits());
                        counted++;
                    end
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2)
                    begin
                        item = tick_cmd(rand_limits());
                    end
                    else if (pick == 2)
                    begin
                        item = move_cmd(pos_x, pos_y, rand_limits());
                        counted++;
                    end
                    else
                    begin
                        item = move_cmd(POS_W'($urandom), POS_W'($urandom), rand_limits());
                        counted++;
                    end
                end
                push_item(item, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_dual_axis_stepper_move_sequencer OK");
        else
            $display("tb_dual_axis_stepper_move_sequencer NOT OK");
        $finish;
    end

endmodule

FILE: dual_axis_stepper_move_sequencer.f
+incdir+rtl
rtl/dasms_pkg.sv
rtl/dual_axis_stepper_move_sequencer.sv
tb/tb_dual_axis_stepper_move_sequencer.sv
